FILE: rtl/ctd_pkg.sv
// ctd_pkg: shared types, constants and helpers for the chunked transfer decoder.
// No dependencies; imported by ctd_parser, ctd_out_buf and the top level.
`timescale 1ns / 1ps

package ctd_pkg;

    // Default width of the chunk size counters
    localparam int LEN_BITS_DEFAULT = 32;

    // Byte constants
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Parser phases
    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,   // skipping line ends before a size
        PH_SIZE  = 3'd1,   // reading hex digits
        PH_EXT   = 3'd2,   // discarding a chunk extension
        PH_AFTCR = 3'd3,   // size line ended in CR, LF may follow
        PH_DATA  = 3'd4,   // passing payload bytes
        PH_ERROR = 3'd5    // sticky error, input ignored
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      result_kind;
        logic       chunk_end;
    } result_t;

    // Hex digit decode
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.val = 4'(c - 8'h30);
            [8'h61:8'h66]: h.val = 4'(c - 8'h57);
            [8'h41:8'h46]: h.val = 4'(c - 8'h37);
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

FILE: rtl/chunked_transfer_decoder_unit.sv
// chunked_transfer_decoder_unit: top level of the chunked transfer decoder.
// A result is registered in the result buffer before it appears on the output.
// Throughput: one input beat per cycle, set by the parser's per-beat update.
// Input stalls only when both result entries are full under output backpressure.
// Reset (rst_n, async, active low) returns the parser to line-end skipping and
// empties the result buffer. Depends on ctd_pkg, ctd_parser, ctd_out_buf.
`timescale 1ns / 1ps

module chunked_transfer_decoder_unit
    import ctd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [1:0] result_kind
    output logic       m_tlast     // chunk_end
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    logic    can_push;
    result_t head;

    assign s_tready = can_push;
    assign in_fire  = s_tvalid && can_push;

    // Byte parser and chunk counter
    ctd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register with skid entry
    ctd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_fire && res_valid),
        .push_data  (res),
        .can_push   (can_push),
        .head_valid (m_tvalid),
        .pop        (m_tready),
        .head_data  (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = head.result_kind;
    assign m_tlast = head.chunk_end;

endmodule

FILE: rtl/ctd_parser.sv
// ctd_parser: chunk size line parser and payload counter, one byte per beat.
// Depends on ctd_pkg.
`timescale 1ns / 1ps

module ctd_parser
    import ctd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,     // input beat accepted this cycle
    input  logic [7:0] in_byte,
    output logic       res_valid,   // a result comes from this beat
    output result_t    res
);

    phase_t              phase_reg, phase_next;
    logic [LEN_BITS-1:0] size_accum_reg, size_accum_next;
    logic [LEN_BITS-1:0] bytes_left_reg, bytes_left_next;

    hex_t                hex;
    logic                is_cr;
    logic                is_lf;
    logic                size_ovf;
    logic [LEN_BITS-1:0] bytes_dec;

    assign hex       = hex_decode(in_byte);
    assign is_cr     = (in_byte == CHAR_CR);
    assign is_lf     = (in_byte == CHAR_LF);
    assign size_ovf  = (size_accum_reg[LEN_BITS-1 -: 4] != 4'd0);
    assign bytes_dec = bytes_left_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SKIP;
            size_accum_reg <= '0;
            bytes_left_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // Next state and result for the current byte
    always_comb
    begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        bytes_left_next = bytes_left_reg;
        res_valid       = 1'b0;
        res.out_byte    = 8'd0;
        res.result_kind = KIND_DATA;
        res.chunk_end   = 1'b0;

        case (phase_reg)
            PH_SKIP:
            begin
                if (is_cr || is_lf)
                begin
                    phase_next = PH_SKIP;
                end
                else if (!hex.ok)
                begin
                    phase_next      = PH_ERROR;
                    res_valid       = 1'b1;
                    res.result_kind = KIND_ERROR;
                end
                else
                begin
                    size_accum_next = {{(LEN_BITS-4){1'b0}}, hex.val};
                    phase_next      = PH_SIZE;
                end
            end

            PH_SIZE, PH_EXT:
            begin
                if (phase_reg == PH_SIZE && hex.ok)
                begin
                    if (size_ovf)
                    begin
                        phase_next      = PH_ERROR;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                    end
                    else
                    begin
                        size_accum_next = {size_accum_reg[LEN_BITS-5:0], hex.val};
                    end
                end
                else if (is_cr || is_lf)
                begin
                    // line end: commit the size
                    size_accum_next = '0;
                    if (size_accum_reg == '0)
                    begin
                        phase_next      = PH_SKIP;
                        res_valid       = 1'b1;
                        res.result_kind = KIND_DONE;
                    end
                    else
                    begin
                        bytes_left_next = size_accum_reg;
                        phase_next      = is_cr ? PH_AFTCR : PH_DATA;
                    end
                end
                else
                begin
                    phase_next = PH_EXT;
                end
            end

            PH_AFTCR, PH_DATA:
            begin
                if (phase_reg == PH_AFTCR && is_lf)
                begin
                    phase_next = PH_DATA;
                end
                else if (bytes_left_reg == '0)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    // pass one payload byte
                    bytes_left_next = bytes_dec;
                    res_valid       = 1'b1;
                    res.out_byte    = in_byte;
                    res.result_kind = KIND_DATA;
                    res.chunk_end   = (bytes_dec == '0);
                    phase_next      = (bytes_dec == '0) ? PH_SKIP : PH_DATA;
                end
            end

            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

endmodule

FILE: rtl/ctd_out_buf.sv
// ctd_out_buf: two-entry result register with skid entry, decouples output stalls.
// Depends on ctd_pkg.
`timescale 1ns / 1ps

module ctd_out_buf
    import ctd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,    // registered, no path from pop side
    output logic    head_valid,
    input  logic    pop,
    output result_t head_data
);

    logic [1:0] count_reg, count_next;
    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic       do_pop;

    assign do_pop     = pop && (count_reg != 2'd0);
    assign can_push   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = e0_reg;

    // Occupancy counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload entries
    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    // Head moves up on pop, new beat lands in the first free slot
    always_comb
    begin
        count_next = count_reg;
        e0_next    = e0_reg;
        e1_next    = e1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    e0_next    = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && do_pop)
                begin
                    e0_next = push_data;
                end
                else if (push)
                begin
                    e1_next    = push_data;
                    count_next = 2'd2;
                end
                else if (do_pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (do_pop)
                begin
                    e0_next    = e1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

endmodule

FILE: tb/sv/chunked_decode_checker.sv
// chunked_decode_checker: watches both streams of the chunked transfer decoder,
// predicts each result beat from the input beats and compares them in order.
// Depends on ctd_pkg for the phase, kind and result types.
`timescale 1ns / 1ps

module chunked_decode_checker
    import ctd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,     // [7:0] out_byte
    input  logic [1:0] m_tuser,     // [1:0] result_kind
    input  logic       m_tlast,     // chunk_end
    output int         mismatches,
    output int         outstanding,
    output int         payload_seen,
    output int         done_seen,
    output int         error_seen
);

    // Decoder state as predicted
    phase_t      dec_phase;
    logic [63:0] size_acc;
    logic [63:0] bytes_left;
    result_t     expected_results [$];
    int          err_total;
    int          n_payload;
    int          n_done;
    int          n_error;

    // Hex digit value, -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
        return -1;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input kind_t k,
                                         input logic last);
        result_t r;
        r.out_byte    = b;
        r.result_kind = k;
        r.chunk_end   = last;
        expected_results.push_back(r);
    endfunction

    task automatic enter_error();
        dec_phase = PH_ERROR;
        queue_result(8'h00, KIND_ERROR, 1'b0);
    endtask

    // Size line is over: zero size completes, otherwise payload follows
    task automatic close_size_line(input phase_t next_phase);
        if (size_acc == 64'd0)
        begin
            dec_phase = PH_SKIP;
            queue_result(8'h00, KIND_DONE, 1'b0);
        end
        else
        begin
            bytes_left = size_acc;
            dec_phase  = next_phase;
        end
        size_acc = 64'd0;
    endtask

    task automatic forward_payload(input logic [7:0] c);
        bytes_left = bytes_left - 64'd1;
        dec_phase  = (bytes_left == 64'd0) ? PH_SKIP : PH_DATA;
        queue_result(c, KIND_DATA, bytes_left == 64'd0);
    endtask

    // One accepted input beat through the predicted decoder
    task automatic decode_byte(input logic [7:0] c);
        int nib;
        nib = nibble_of(c);
        case (dec_phase)
            PH_SKIP:
            begin
                if (c != CHAR_CR && c != CHAR_LF)
                begin
                    if (nib < 0)
                    begin
                        enter_error();
                    end
                    else
                    begin
                        size_acc  = 64'(nib);
                        dec_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE:
            begin
                if (nib >= 0)
                begin
                    if ((size_acc >> (LEN_BITS - 4)) != 64'd0)
                        enter_error();
                    else
                        size_acc = (size_acc << 4) | 64'(nib);
                end
                else if (c == CHAR_CR)
                    close_size_line(PH_AFTCR);
                else if (c == CHAR_LF)
                    close_size_line(PH_DATA);
                else
                    dec_phase = PH_EXT;
            end
            PH_EXT:
            begin
                if (c == CHAR_CR)
                    close_size_line(PH_AFTCR);
                else if (c == CHAR_LF)
                    close_size_line(PH_DATA);
            end
            PH_AFTCR:
            begin
                if (c == CHAR_LF)
                    dec_phase = PH_DATA;
                else if (bytes_left == 64'd0)
                    dec_phase = PH_SKIP;
                else
                    forward_payload(c);
            end
            PH_DATA:
            begin
                if (bytes_left == 64'd0)
                    dec_phase = PH_SKIP;
                else
                    forward_payload(c);
            end
            default: dec_phase = PH_ERROR;
        endcase
    endtask

    // Compare result beats first, then predict from the input beat
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            dec_phase  = PH_SKIP;
            size_acc   = 64'd0;
            bytes_left = 64'd0;
            expected_results.delete();
            err_total  = 0;
            n_payload  = 0;
            n_done     = 0;
            n_error    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    err_total++;
                    $display("%0t: unexpected result beat: byte=%02h kind=%0d last=%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.out_byte || m_tuser !== want.result_kind ||
                        m_tlast !== want.chunk_end)
                    begin
                        err_total++;
                        $display("%0t: result mismatch: expected byte=%02h kind=%0d last=%0b,",
                                 $time, want.out_byte, want.result_kind, want.chunk_end,
                                 " got byte=%02h kind=%0d last=%0b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                    case (want.result_kind)
                        KIND_DATA: n_payload++;
                        KIND_DONE: n_done++;
                        default:   n_error++;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        mismatches   <= err_total;
        outstanding  <= expected_results.size();
        payload_seen <= n_payload;
        done_seen    <= n_done;
        error_seen   <= n_error;
    end

endmodule

FILE: tb/sv/tb_chunked_transfer_decoder_unit.sv
// tb_chunked_transfer_decoder_unit: drives chunked byte streams into the decoder
// with random gaps and output stalls; chunked_decode_checker does the checking.
// Depends on ctd_pkg, chunked_transfer_decoder_unit and chunked_decode_checker.
`timescale 1ns / 1ps

module tb_chunked_transfer_decoder_unit
    import ctd_pkg::*;
();

    localparam int LEN_BITS     = LEN_BITS_DEFAULT;
    localparam int RANDOM_BEATS = 1450;
    localparam int CYCLE_LIMIT  = 2000000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] out_byte
    logic [1:0] m_tuser;     // [1:0] result_kind
    logic       m_tlast;     // chunk_end

    int mismatches;
    int outstanding;
    int payload_seen;
    int done_seen;
    int error_seen;
    int beats_sent  = 0;
    int chunks_sent = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;  // no input gaps while set

    // Opening sequence: leading line ends, CR LF / LF / lone CR endings,
    // extensions, payload extremes and line-end bytes as payload, zero sizes
    logic [7:0] directed_seq [0:22] = '{
        CHAR_CR, CHAR_LF,
        8'h31, CHAR_CR, CHAR_LF, 8'hFF, CHAR_CR, CHAR_LF,
        8'h32, 8'h3B, 8'h78, CHAR_LF, 8'h00, CHAR_LF,
        8'h31, CHAR_CR, CHAR_CR,
        8'h30, CHAR_CR, CHAR_LF,
        8'h30, 8'h3B, CHAR_LF
    };

    chunked_transfer_decoder_unit #(.LEN_BITS(LEN_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    chunked_decode_checker #(.LEN_BITS(LEN_BITS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .payload_seen (payload_seen),
        .done_seen    (done_seen),
        .error_seen   (error_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic bit is_hex(input logic [7:0] b);
        hex_t h;
        h = hex_decode(b);
        return h.ok;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (upper ? 8'h37 : 8'h57) + 8'(nib);
    endfunction

    // One input beat, with an optional gap before it
    task automatic send_beat(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        beats_sent++;
    endtask

    // Hex size with random case and leading zeros, optional extension, line end
    task automatic send_size_line(input int unsigned size, output bit lone_cr);
        int         ndig;
        int         i;
        int         r;
        bit         upper;
        logic [7:0] b;
        upper = 1'($urandom_range(1));
        ndig  = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(12, 1)) send_beat(8'h30);
        for (i = ndig - 1; i >= 0; i--)
            send_beat(hex_char(4'(size >> (4 * i)), upper ^ ($urandom_range(7) == 0)));
        if ($urandom_range(3) == 0)
        begin
            // extension must open with something that ends the digits
            do b = 8'($urandom_range(255));
            while (is_hex(b) || b == CHAR_CR || b == CHAR_LF);
            send_beat(b);
            repeat ($urandom_range(6))
            begin
                do b = 8'($urandom_range(255));
                while (b == CHAR_CR || b == CHAR_LF);
                send_beat(b);
            end
        end
        r = $urandom_range(9);
        lone_cr = 1'b0;
        if (r < 6)
        begin
            send_beat(CHAR_CR);
            send_beat(CHAR_LF);
        end
        else if (r < 8)
        begin
            send_beat(CHAR_LF);
        end
        else
        begin
            send_beat(CHAR_CR);
            lone_cr = 1'b1;
        end
    endtask

    // Size line, payload, then an optional loose trailing line end
    task automatic send_chunk(input int unsigned size);
        bit         lone_cr;
        logic [7:0] b;
        int         i;
        int         r;
        steady = ($urandom_range(7) == 0);
        send_size_line(size, lone_cr);
        for (i = 0; i < size; i++)
        begin
            b = 8'($urandom_range(255));
            // after a bare CR an LF would still count as line end
            if (i == 0 && lone_cr)
                while (b == CHAR_LF) b = 8'($urandom_range(255));
            send_beat(b);
        end
        r = $urandom_range(9);
        if (r < 6)
        begin
            send_beat(CHAR_CR);
            send_beat(CHAR_LF);
        end
        else if (r == 6)
        begin
            send_beat(CHAR_LF);
        end
        else if (r == 8)
        begin
            repeat ($urandom_range(4, 1))
                send_beat($urandom_range(1) ? CHAR_CR : CHAR_LF);
        end
        chunks_sent++;
    endtask

    // Output side: ready runs broken by stalls
    initial
    begin
        int gap;
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int         r;
        logic [7:0] b;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i]) send_beat(directed_seq[i]);

        // messages of a few chunks, each closed by a zero-size chunk
        while (beats_sent < RANDOM_BEATS)
        begin
            repeat ($urandom_range(5, 1))
            begin
                r = $urandom_range(99);
                if (r < 75)
                    send_chunk($urandom_range(6, 1));
                else if (r < 95)
                    send_chunk($urandom_range(32, 7));
                else
                    send_chunk($urandom_range(300, 33));
            end
            send_chunk(0);
        end

        // sticky error to close the run: oversized or malformed size line
        steady = 1'b0;
        if ($urandom_range(1))
        begin
            repeat (LEN_BITS / 4) send_beat(hex_char(4'hF, 1'($urandom_range(1))));
            send_beat(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end
        else
        begin
            do b = 8'($urandom_range(255));
            while (is_hex(b) || b == CHAR_CR || b == CHAR_LF);
            send_beat(b);
        end
        // all of this must be dropped
        repeat (8) send_beat(8'($urandom_range(255)));
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d input beats in %0d chunks,", beats_sent, chunks_sent,
                 " directed opening then random messages");
        $display("checked %0d payload beats, %0d completions and %0d size-line errors",
                 payload_seen, done_seen, error_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

FILE: chunked_transfer_decoder_unit.f
rtl/ctd_pkg.sv
rtl/ctd_parser.sv
rtl/ctd_out_buf.sv
rtl/chunked_transfer_decoder_unit.sv
tb/sv/chunked_decode_checker.sv
tb/sv/tb_chunked_transfer_decoder_unit.sv
